// ===== rtl/lgfl_pkg.sv =====
// Shared types and constants for the LED grayscale frame loader.
package lgfl_pkg;

	localparam int DRIVER_COUNT        = 2;
	localparam int CHANNELS_PER_DRIVER = 16;
	localparam int CHAN_TOTAL          = DRIVER_COUNT * CHANNELS_PER_DRIVER;
	localparam int CHAN_W              = (CHAN_TOTAL > 1) ? $clog2(CHAN_TOTAL) : 1;

	localparam int MODE_W  = 3;
	localparam int CH_W    = 6;
	localparam int LEVEL_W = 12;
	localparam int DOT_W   = 6;

	localparam logic [MODE_W-1:0] MODE_WRITE      = 3'd0;
	localparam logic [MODE_W-1:0] MODE_READ       = 3'd1;
	localparam logic [MODE_W-1:0] MODE_FILL       = 3'd2;
	localparam logic [MODE_W-1:0] MODE_UPDATE     = 3'd3;
	localparam logic [MODE_W-1:0] MODE_DOT_FILL   = 3'd4;
	localparam logic [MODE_W-1:0] MODE_LATCH_DONE = 3'd5;

	typedef struct packed {
		logic [MODE_W-1:0]  mode;
		logic [CH_W-1:0]    channel;
		logic [LEVEL_W-1:0] level;
		logic               fault_line_low;
	} cmd_item_t;

	typedef struct packed {
		logic [LEVEL_W-1:0] read_level;
		logic [LEVEL_W-1:0] shift_word;
		logic               word_valid;
		logic               dot_mode;
		logic               lead_clock;
		logic               latch_request;
		logic               update_refused;
		logic               latch_pending;
		logic               bad_channel;
		logic               led_fault;
		logic               last;
	} res_item_t;

	typedef enum logic [0:0] {
		ST_IDLE,
		ST_STREAM
	} state_t;

	// controller -> datapath
	typedef struct packed {
		logic take_single;
		logic start_stream;
		logic emit;
	} ctl_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic can_load;
		logic latch_waiting;
		logic last_idx;
	} dp_sts_t;

endpackage

// ===== rtl/lgfl_if.sv =====
// Valid/ready channel interfaces for commands and results.
interface lgfl_cmd_if;
	logic                  valid;
	logic                  ready;
	lgfl_pkg::cmd_item_t   payload;

	modport source (output valid, output payload, input ready);
	modport sink   (input valid, input payload, output ready);
endinterface

interface lgfl_res_if;
	logic                  valid;
	logic                  ready;
	lgfl_pkg::res_item_t   payload;

	modport source (output valid, output payload, input ready);
	modport sink   (input valid, input payload, output ready);
endinterface

// ===== rtl/led_grayscale_frame_loader_core.sv =====
// Top level of the LED grayscale frame loader.
// Commands arrive on cmd (valid/ready, payload mode/channel/level/fault_line_low);
// results leave on res (valid/ready), one per transfer, the final one marked last.
// Write, read, fill, latch-done, refused-update and unused modes each give one
// result, registered in the cycle after the command transfer; with res ready held
// high such commands are taken one per cycle.
// An accepted update or dot-correction fill gives one word per channel,
// highest channel first: the command transfer moves the controller into its
// stream state, which loads one word per cycle into the result register while
// res is ready; cmd is not ready while words are streaming.
// The single result register sets the pace; when res is stalled the result
// holds and cmd stays not ready until the result is taken.
// Reset clears the level store, the pending-latch and after-dot-load flags
// and empties the result register at once; no clearing pass is needed.
module led_grayscale_frame_loader_core (
	input  logic       clk,
	input  logic       arst_n,
	lgfl_cmd_if.sink   cmd,
	lgfl_res_if.source res
);
	import lgfl_pkg::*;

	ctl_cmd_t ctl;
	dp_sts_t  sts;

	lgfl_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd.valid),
		.cmd_mode  (cmd.payload.mode),
		.sts       (sts),
		.cmd_ready (cmd.ready),
		.ctl       (ctl)
	);

	lgfl_datapath u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.item      (cmd.payload),
		.ctl       (ctl),
		.out_ready (res.ready),
		.sts       (sts),
		.out_valid (res.valid),
		.out_item  (res.payload)
	);

endmodule

// ===== rtl/lgfl_ctrl.sv =====
// Controller state machine: command acceptance and word streaming.
module lgfl_ctrl (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cmd_valid,
	input  logic [lgfl_pkg::MODE_W-1:0] cmd_mode,
	input  lgfl_pkg::dp_sts_t         sts,
	output logic                      cmd_ready,
	output lgfl_pkg::ctl_cmd_t        ctl
);
	import lgfl_pkg::*;

	state_t state_q, state_nxt;
	logic   acc;
	logic   is_stream;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	// updates stream only when no latch is pending; a refused update is one result
	assign is_stream = (cmd_mode == MODE_DOT_FILL) ||
	                   ((cmd_mode == MODE_UPDATE) && !sts.latch_waiting);

	always_comb begin
		state_nxt = state_q;
		cmd_ready = 1'b0;
		acc       = 1'b0;
		ctl       = '0;
		unique case (state_q)
			ST_IDLE: begin
				cmd_ready = sts.can_load;
				acc       = cmd_valid && sts.can_load;
				if (acc && is_stream) begin
					ctl.start_stream = 1'b1;
					state_nxt        = ST_STREAM;
				end else if (acc) begin
					ctl.take_single = 1'b1;
				end
			end
			ST_STREAM: begin
				ctl.emit = sts.can_load;
				if (sts.can_load && sts.last_idx) begin
					state_nxt = ST_IDLE;
				end
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

endmodule

// ===== rtl/lgfl_datapath.sv =====
// Datapath: level store, latch flags, word counter and result register.
module lgfl_datapath (
	input  logic                 clk,
	input  logic                 arst_n,
	input  lgfl_pkg::cmd_item_t  item,
	input  lgfl_pkg::ctl_cmd_t   ctl,
	input  logic                 out_ready,
	output lgfl_pkg::dp_sts_t    sts,
	output logic                 out_valid,
	output lgfl_pkg::res_item_t  out_item
);
	import lgfl_pkg::*;

	logic [LEVEL_W-1:0] store_q [CHAN_TOTAL];
	logic               latch_waiting_q;
	logic               after_dot_q;
	logic [CHAN_W-1:0]  idx_q;
	logic               dot_q;
	logic               lead_q;
	logic [DOT_W-1:0]   dval_q;
	logic               fault_q;
	logic               out_valid_q;
	res_item_t          out_q;

	logic               can_load;
	logic               last_idx;
	logic               in_range;
	logic [CHAN_W-1:0]  rd_addr;
	logic [LEVEL_W-1:0] rd_data;
	logic               lw_nxt;
	res_item_t          single_r;
	res_item_t          word_r;

	assign can_load = !out_valid_q || out_ready;
	assign last_idx = (idx_q == CHAN_W'(CHAN_TOTAL - 1));
	assign in_range = ({1'b0, item.channel} < (CH_W + 1)'(CHAN_TOTAL));

	// stream reads highest channel first
	assign rd_addr = ctl.emit ? (CHAN_W'(CHAN_TOTAL - 1) - idx_q) : item.channel[CHAN_W-1:0];
	assign rd_data = store_q[rd_addr];

	always_comb begin
		single_r           = '0;
		single_r.led_fault = ~item.fault_line_low;
		single_r.last      = 1'b1;
		lw_nxt             = latch_waiting_q;
		unique case (item.mode)
			MODE_WRITE: begin
				single_r.bad_channel = ~in_range;
			end
			MODE_READ: begin
				single_r.bad_channel = ~in_range;
				single_r.read_level  = in_range ? rd_data : '0;
			end
			MODE_UPDATE: begin
				single_r.update_refused = 1'b1;
			end
			MODE_LATCH_DONE: begin
				lw_nxt = 1'b0;
			end
			default: begin
			end
		endcase
		single_r.latch_pending = lw_nxt;
	end

	always_comb begin
		word_r               = '0;
		word_r.shift_word    = dot_q ? {{(LEVEL_W - DOT_W){1'b0}}, dval_q} : rd_data;
		word_r.word_valid    = 1'b1;
		word_r.dot_mode      = dot_q;
		word_r.lead_clock    = lead_q;
		word_r.latch_request = last_idx;
		word_r.latch_pending = ~dot_q;
		word_r.led_fault     = fault_q;
		word_r.last          = last_idx;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < CHAN_TOTAL; i++) begin
				store_q[i] <= '0;
			end
		end else if (ctl.take_single) begin
			if (item.mode == MODE_WRITE && in_range) begin
				store_q[item.channel[CHAN_W-1:0]] <= item.level;
			end else if (item.mode == MODE_FILL) begin
				for (int i = 0; i < CHAN_TOTAL; i++) begin
					store_q[i] <= item.level;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			latch_waiting_q <= 1'b0;
			after_dot_q     <= 1'b0;
			idx_q           <= '0;
			dot_q           <= 1'b0;
			lead_q          <= 1'b0;
			out_valid_q     <= 1'b0;
		end else begin
			if (ctl.take_single) begin
				latch_waiting_q <= lw_nxt;
			end
			if (ctl.start_stream) begin
				idx_q <= '0;
				if (item.mode == MODE_DOT_FILL) begin
					dot_q           <= 1'b1;
					lead_q          <= 1'b0;
					latch_waiting_q <= 1'b0;
					after_dot_q     <= 1'b1;
				end else begin
					dot_q           <= 1'b0;
					lead_q          <= ~after_dot_q;
					latch_waiting_q <= 1'b1;
					after_dot_q     <= 1'b0;
				end
			end
			if (ctl.emit) begin
				idx_q  <= idx_q + 1'b1;
				lead_q <= 1'b0;
			end
			if (ctl.take_single || ctl.emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.start_stream) begin
			dval_q  <= item.level[DOT_W-1:0];
			fault_q <= ~item.fault_line_low;
		end
		if (ctl.take_single) begin
			out_q <= single_r;
		end else if (ctl.emit) begin
			out_q <= word_r;
		end
	end

	assign sts.can_load      = can_load;
	assign sts.latch_waiting = latch_waiting_q;
	assign sts.last_idx      = last_idx;
	assign out_valid         = out_valid_q;
	assign out_item          = out_q;

	a_load_has_room: assert property (@(posedge clk) disable iff (!arst_n)
		(ctl.take_single || ctl.emit) |-> can_load)
		else $error("result register overwritten while full");

	a_one_command: assert property (@(posedge clk) disable iff (!arst_n)
		!((ctl.take_single || ctl.start_stream) && ctl.emit))
		else $error("command accepted during word stream");

	a_stream_starts_at_zero: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.start_stream |=> (idx_q == '0))
		else $error("word counter not cleared at stream start");

	a_lead_only_first_gs: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_q.lead_clock) |-> (out_q.word_valid && !out_q.dot_mode))
		else $error("lead clock flagged on a non-grayscale result");

	a_dot_clears_latch: assert property (@(posedge clk) disable iff (!arst_n)
		(ctl.emit && dot_q) |-> !latch_waiting_q)
		else $error("latch pending during dot-correction stream");

endmodule
